@@ hw/rtl/chenc_pkg.sv @@
// shared types and constants of the canonical huffman encoder
`default_nettype none

package chenc_pkg;

  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int MAX_CODE_BITS_DEF = 15;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 4;
  localparam int CODE_W = 15;
  localparam int PREV_W = 16;
  localparam int PEND_W = 7;
  localparam int CNT_W  = 3;
  localparam int BYTE_W = 8;
  localparam int ACC_W  = PEND_W + CODE_W;
  localparam int NBIT_W = 5;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [1:0]        opcode;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              final_byte;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/canonical_huffman_encoder_top.sv @@
// top level of the canonical huffman encoder
// results pass through the input stage register and the output queue to the output
// one input per cycle when not stalled; output drains one byte per cycle when ready
// an encode that completes two bytes stalls input only when the output queue backs up
// reset clears valid bits, code counter, pending bits and output queue
// code and length memories are not cleared; entries are used only once valid
`default_nettype none

module canonical_huffman_encoder_top import chenc_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[1:0], symbol[9:2], code_length[13:10], zero pad
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  // final_byte[0]
  output logic             m_axis_tuser
);

  stage_t               stage;
  push_t                push;
  result_t              head;
  logic                 accept;
  logic                 fire;
  logic                 pop;
  logic                 room;
  logic                 not_empty;
  logic [Q_LVL_W-1:0]   level;

  assign fire          = stage.valid && room;
  assign s_axis_tready = !stage.valid || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  chenc_table #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .advance     (fire),
    .opcode      (s_axis_tdata[1:0]),
    .symbol      (s_axis_tdata[9:2]),
    .code_length (s_axis_tdata[13:10]),
    .stage       (stage)
  );

  chenc_packer u_packer (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .stage (stage),
    .push  (push)
  );

  chenc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room),
    .level     (level)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = head.out_byte;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tuser  = head.final_byte;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= Q_LVL_W'(Q_DEPTH))
    else $error("output queue overfilled");

  a_flush_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("flush byte not marked last");

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> stage.valid && !room)
    else $error("input stalled without a waiting item");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |=> level != '0)
    else $error("pushed bytes lost");

endmodule

`default_nettype wire

@@ hw/rtl/chenc_table.sv @@
// code table: canonical code assignment, code and length memories, input stage register
`default_nettype none

module chenc_table import chenc_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             advance,
  input  wire logic [1:0]       opcode,
  input  wire logic [SYM_W-1:0] symbol,
  input  wire logic [LEN_W-1:0] code_length,
  output stage_t                stage
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [MAX_CODE_BITS-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]         len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]  valid_bits;

  logic [PREV_W-1:0] previous_code;
  logic [LEN_W-1:0]  previous_length;

  logic [MAX_CODE_BITS-1:0] code_rd;
  logic [LEN_W-1:0]         len_rd;
  logic                     stage_valid;
  logic [1:0]               stage_op;
  logic                     stage_hit;

  logic [IDX_W-1:0]  idx;
  logic              sym_ok;
  logic              len_ok;
  logic              do_load;
  logic [LEN_W-1:0]  shift;
  logic [PREV_W-1:0] code_next;
  logic [PREV_W-1:0] len_mask;
  logic [PREV_W-1:0] code_masked;
  logic [LEN_W-1:0]  len_store;

  assign idx    = symbol[IDX_W-1:0];
  assign sym_ok = 32'(symbol) < SYMBOL_COUNT;
  assign len_ok = 32'(code_length) <= MAX_CODE_BITS;

  always_comb begin
    do_load     = accept && (opcode == OP_LOAD) && sym_ok && len_ok;
    shift       = (code_length > previous_length) ? (code_length - previous_length)
                                                  : '0;
    code_next   = (previous_code + PREV_W'(1)) << shift;
    len_mask    = (PREV_W'(1) << code_length) - PREV_W'(1);
    code_masked = (code_length == '0) ? '0 : (code_next & len_mask);
    len_store   = (code_length == '0) ? LEN_W'(1) : code_length;
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= code_masked[MAX_CODE_BITS-1:0];
      len_mem[idx]  <= len_store;
    end
    if (accept) begin
      code_rd <= code_mem[idx];
      len_rd  <= len_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits      <= '0;
      previous_code   <= '1;
      previous_length <= '0;
    end else if (accept) begin
      unique case (opcode)
        OP_LOAD: begin
          if (do_load) begin
            valid_bits[idx] <= 1'b1;
            previous_code   <= code_next;
            previous_length <= code_length;
          end
        end
        OP_CLEAR: begin
          valid_bits      <= '0;
          previous_code   <= '1;
          previous_length <= '0;
        end
        OP_ENCODE, OP_FLUSH: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op  <= opcode;
      stage_hit <= sym_ok && valid_bits[idx];
    end
  end

  always_comb begin
    stage.valid  = stage_valid;
    stage.opcode = stage_op;
    stage.hit    = stage_hit;
    stage.code   = CODE_W'(code_rd);
    stage.length = len_rd;
  end

endmodule

`default_nettype wire

@@ hw/rtl/chenc_packer.sv @@
// bit packer: appends codes to the pending bits and forms output bytes
`default_nettype none

module chenc_packer import chenc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  stage_t    stage,
  output push_t     push
);

  logic [PEND_W-1:0] pending_bits;
  logic [CNT_W-1:0]  pending_count;
  logic              bits_since_flush;

  logic [PEND_W-1:0] pending_bits_next;
  logic [CNT_W-1:0]  pending_count_next;
  logic              bits_since_flush_next;

  logic [ACC_W-1:0]  acc;
  logic [NBIT_W-1:0] n_total;
  logic [NBIT_W-1:0] n_rest;
  logic [ACC_W-1:0]  rest_mask;
  logic [ACC_W-1:0]  byte0_sh;
  logic [ACC_W-1:0]  byte1_sh;
  logic [CODE_W-1:0] flush_sh;

  always_comb begin
    acc       = (ACC_W'(pending_bits) << stage.length) | ACC_W'(stage.code);
    n_total   = NBIT_W'(pending_count) + NBIT_W'(stage.length);
    byte0_sh  = acc >> (n_total - NBIT_W'(8));
    byte1_sh  = acc >> (n_total - NBIT_W'(16));
    n_rest    = (n_total >= NBIT_W'(16)) ? (n_total - NBIT_W'(16))
              : (n_total >= NBIT_W'(8))  ? (n_total - NBIT_W'(8)) : n_total;
    rest_mask = (ACC_W'(1) << n_rest) - ACC_W'(1);
    flush_sh  = CODE_W'(pending_bits) << (LEN_W'(8) - LEN_W'(pending_count));

    pending_bits_next     = pending_bits;
    pending_count_next    = pending_count;
    bits_since_flush_next = bits_since_flush;
    push                  = '0;

    if (fire) begin
      case (stage.opcode)
        OP_ENCODE: begin
          if (stage.hit) begin
            pending_bits_next     = PEND_W'(acc & rest_mask);
            pending_count_next    = CNT_W'(n_rest);
            bits_since_flush_next = 1'b1;
            if (n_total >= NBIT_W'(16)) begin
              push.count         = 2'd2;
              push.res0.out_byte = byte0_sh[BYTE_W-1:0];
              push.res1.out_byte = byte1_sh[BYTE_W-1:0];
              push.res1.last_of_run = 1'b1;
            end else if (n_total >= NBIT_W'(8)) begin
              push.count            = 2'd1;
              push.res0.out_byte    = byte0_sh[BYTE_W-1:0];
              push.res0.last_of_run = 1'b1;
            end
          end
        end
        OP_FLUSH: begin
          if ((pending_count != '0) || !bits_since_flush) begin
            push.count            = 2'd1;
            push.res0.out_byte    = flush_sh[BYTE_W-1:0];
            push.res0.last_of_run = 1'b1;
            push.res0.final_byte  = 1'b1;
          end
          pending_bits_next     = '0;
          pending_count_next    = '0;
          bits_since_flush_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits     <= '0;
      pending_count    <= '0;
      bits_since_flush <= 1'b0;
    end else begin
      pending_bits     <= pending_bits_next;
      pending_count    <= pending_count_next;
      bits_since_flush <= bits_since_flush_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/chenc_outq.sv @@
// output queue: takes up to two bytes per cycle, hands out one per cycle when popped
`default_nettype none

module chenc_outq import chenc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  push_t            push,
  input  wire logic        pop,
  output result_t          head,
  output logic             not_empty,
  output logic             room,
  output logic [Q_LVL_W-1:0] level
);

  result_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   rptr;
  logic [Q_PTR_W-1:0]   wptr;
  logic [Q_LVL_W-1:0]   count;
  logic [Q_LVL_W-1:0]   count_next;

  assign count_next = count + Q_LVL_W'(push.count) - Q_LVL_W'(pop);
  assign head       = slots[rptr];
  assign not_empty  = count != '0;
  assign room       = count <= Q_LVL_W'(Q_DEPTH - 2);
  assign level      = count;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      slots[wptr + Q_PTR_W'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      rptr  <= rptr + Q_PTR_W'(pop);
      wptr  <= wptr + Q_PTR_W'(push.count);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire
